// File: hw/rtl/ikrq_pkg.sv
// Package for the IR key repeat qualifier: widths, event and register codes,
// result record type and the time compare helper. No dependencies.
`timescale 1ns / 1ps
package ikrq_pkg;

    localparam int TIME_BITS          = 12;
    localparam int KEY_BITS           = 8;
    localparam int DELAY_BITS         = 12;
    localparam int RELEASE_TIMEOUT_MS = 500;
    localparam int CMP_BITS           = (TIME_BITS > DELAY_BITS) ? TIME_BITS : DELAY_BITS;

    localparam int CNT_BITS   = 8;
    localparam int TYPE_BITS  = 3;
    localparam int INDEX_BITS = 3;
    localparam int IN_DATA_BITS  = 16;
    localparam int OUT_DATA_BITS = 16;

    typedef enum logic [TYPE_BITS-1:0] {
        EVT_KEY         = 3'd0,
        EVT_QUIT        = 3'd1,
        EVT_POWEROFF    = 3'd2,
        EVT_FULLSCREEN  = 3'd3,
        EVT_DEINTERLACE = 3'd4
    } event_type_t;

    typedef enum logic [INDEX_BITS-1:0] {
        REG_REPEAT_EMULATION   = 3'd0,
        REG_HOTKEYS_ENABLE     = 3'd1,
        REG_QUIT_KEY           = 3'd2,
        REG_POWEROFF_KEY       = 3'd3,
        REG_FULLSCREEN_KEY     = 3'd4,
        REG_DEINTERLACE_KEY    = 3'd5,
        REG_REPEAT_DELAY_MS    = 3'd6,
        REG_REPEAT_INTERVAL_MS = 3'd7
    } reg_index_t;

    typedef struct packed {
        event_type_t         event_type;
        logic [KEY_BITS-1:0] event_key;
        logic                is_repeat;
        logic                is_release;
        logic                last_of_run;
    } result_t;

    function automatic logic time_lt(input logic [TIME_BITS-1:0]  t,
                                     input logic [DELAY_BITS-1:0] d);
        return CMP_BITS'(t) < CMP_BITS'(d);
    endfunction

endpackage

// File: hw/rtl/ir_key_repeat_qualifier.sv
// IR key repeat qualifier top level: key report / tick qualification, state,
// configuration registers and a two-entry result buffer. Uses ikrq_pkg.
`timescale 1ns / 1ps
// One input transaction is taken per cycle when it yields at most one result and m_axis
// is not stalled; one that yields a release plus an event fills the two-entry result
// buffer, and the next waits until one result is taken. All qualification is done in
// the accepting cycle and written straight into the result buffer, so the result
// appears on m_axis in the cycle after acceptance. Config writes are always taken.
module ir_key_repeat_qualifier
    import ikrq_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_axis_tvalid,
    output logic                     s_axis_tready,
    input  logic [IN_DATA_BITS-1:0]  s_axis_tdata,   // [7:0] key_code, [15:8] repeat_count
    input  logic                     s_axis_tuser,   // [0] kind
    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    output logic [OUT_DATA_BITS-1:0] m_axis_tdata,   // [7:0] event_key, [8] is_repeat,
                                                     // [9] is_release, [15:10] zero
    output logic [TYPE_BITS-1:0]     m_axis_tuser,   // [2:0] event_type
    output logic                     m_axis_tlast,   // last_of_run
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [INDEX_BITS-1:0]    cfg_index,
    input  logic [DELAY_BITS-1:0]    cfg_data
);

    logic                  rep_emu_reg, hk_en_reg;
    logic [KEY_BITS-1:0]   quit_key_reg, poweroff_key_reg, fullscreen_key_reg, deint_key_reg;
    logic [DELAY_BITS-1:0] delay_reg, interval_reg;

    logic [TIME_BITS-1:0]  first_reg, first_next, last_reg, last_next;
    logic                  repeating_reg, repeating_next;
    logic [KEY_BITS-1:0]   held_key_reg, held_key_next;
    logic                  held_valid_reg, held_valid_next;
    logic                  stopped_reg, stopped_next;

    result_t               res_reg [2];
    logic [1:0]            cnt_reg;
    logic                  head_reg;

    logic                  in_acc, out_acc;
    logic                  kind;
    logic [KEY_BITS-1:0]   key;
    logic [CNT_BITS-1:0]   rcount;
    logic [TIME_BITS-1:0]  first_inc, last_inc;
    logic                  same, is_rep, drop, do_event, emit_rel, emit_evt;
    result_t               rel_res, evt_res;
    logic [1:0]            n_res;

    assign kind   = s_axis_tuser;
    assign key    = s_axis_tdata[KEY_BITS-1:0];
    assign rcount = s_axis_tdata[KEY_BITS +: CNT_BITS];

    assign s_axis_tready = (cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && m_axis_tready);
    assign in_acc  = s_axis_tvalid && s_axis_tready;
    assign out_acc = m_axis_tvalid && m_axis_tready;
    assign cfg_ready = 1'b1;

    assign m_axis_tvalid = (cnt_reg != 2'd0);
    assign m_axis_tuser  = res_reg[head_reg].event_type;
    assign m_axis_tdata  = {{(OUT_DATA_BITS-KEY_BITS-2){1'b0}},
                            res_reg[head_reg].is_release,
                            res_reg[head_reg].is_repeat,
                            res_reg[head_reg].event_key};
    assign m_axis_tlast  = res_reg[head_reg].last_of_run;

    assign first_inc = (first_reg == {TIME_BITS{1'b1}}) ? first_reg : first_reg + 1'b1;
    assign last_inc  = (last_reg  == {TIME_BITS{1'b1}}) ? last_reg  : last_reg  + 1'b1;
    assign same      = held_valid_reg && (key == held_key_reg);

    always_comb begin
        first_next      = first_reg;
        last_next       = last_reg;
        repeating_next  = repeating_reg;
        held_key_next   = held_key_reg;
        held_valid_next = held_valid_reg;
        stopped_next    = stopped_reg;
        emit_rel        = 1'b0;
        emit_evt        = 1'b0;
        do_event        = 1'b0;
        drop            = 1'b0;
        is_rep          = (rcount != '0) ||
                          (rep_emu_reg && same && time_lt(last_reg, delay_reg));
        evt_res         = '{EVT_KEY, key, 1'b0, 1'b0, 1'b1};

        if (!stopped_reg) begin
            if (kind) begin
                first_next = first_inc;
                last_next  = last_inc;
                if (repeating_reg &&
                    (CMP_BITS'(last_inc) >= CMP_BITS'(RELEASE_TIMEOUT_MS))) begin
                    emit_rel        = held_valid_reg;
                    repeating_next  = 1'b0;
                    held_valid_next = 1'b0;
                    held_key_next   = '0;
                end
            end else if (!is_rep) begin
                if (same && time_lt(first_reg, delay_reg)) begin
                    drop = 1'b1;
                end else begin
                    emit_rel        = repeating_reg && held_valid_reg;
                    held_key_next   = key;
                    held_valid_next = 1'b1;
                    repeating_next  = 1'b0;
                    first_next      = '0;
                    last_next       = '0;
                    do_event        = 1'b1;
                end
            end else begin
                if (time_lt(last_reg, interval_reg)) begin
                    drop = 1'b1;
                end else if (time_lt(first_reg, delay_reg)) begin
                    drop = 1'b1;
                    if (rep_emu_reg) begin
                        last_next = '0;
                    end
                end else begin
                    repeating_next = 1'b1;
                    last_next      = '0;
                    do_event       = 1'b1;
                end
            end
        end

        if (do_event) begin
            priority if (hk_en_reg && key == quit_key_reg) begin
                evt_res      = '{EVT_QUIT, '0, 1'b0, 1'b0, 1'b1};
                emit_evt     = 1'b1;
                stopped_next = 1'b1;
            end else if (hk_en_reg && key == poweroff_key_reg) begin
                evt_res      = '{EVT_POWEROFF, '0, 1'b0, 1'b0, 1'b1};
                emit_evt     = 1'b1;
                stopped_next = 1'b1;
            end else if (hk_en_reg && key == fullscreen_key_reg) begin
                evt_res  = '{EVT_FULLSCREEN, '0, 1'b0, 1'b0, 1'b1};
                emit_evt = !repeating_next;
            end else if (hk_en_reg && key == deint_key_reg) begin
                evt_res  = '{EVT_DEINTERLACE, '0, 1'b0, 1'b0, 1'b1};
                emit_evt = !repeating_next;
            end else begin
                evt_res  = '{EVT_KEY, key, repeating_next, 1'b0, 1'b1};
                emit_evt = 1'b1;
            end
        end

        rel_res = '{EVT_KEY, held_key_reg, 1'b0, 1'b1, !emit_evt};
        n_res   = {1'b0, emit_rel} + {1'b0, emit_evt};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rep_emu_reg        <= 1'b0;
            hk_en_reg          <= 1'b0;
            quit_key_reg       <= KEY_BITS'(0);
            poweroff_key_reg   <= KEY_BITS'(1);
            fullscreen_key_reg <= KEY_BITS'(2);
            deint_key_reg      <= KEY_BITS'(3);
            delay_reg          <= DELAY_BITS'(350);
            interval_reg       <= DELAY_BITS'(100);
        end else if (cfg_valid && cfg_ready) begin
            unique case (reg_index_t'(cfg_index))
                REG_REPEAT_EMULATION:   rep_emu_reg        <= cfg_data[0];
                REG_HOTKEYS_ENABLE:     hk_en_reg          <= cfg_data[0];
                REG_QUIT_KEY:           quit_key_reg       <= cfg_data[KEY_BITS-1:0];
                REG_POWEROFF_KEY:       poweroff_key_reg   <= cfg_data[KEY_BITS-1:0];
                REG_FULLSCREEN_KEY:     fullscreen_key_reg <= cfg_data[KEY_BITS-1:0];
                REG_DEINTERLACE_KEY:    deint_key_reg      <= cfg_data[KEY_BITS-1:0];
                REG_REPEAT_DELAY_MS:    delay_reg          <= cfg_data;
                REG_REPEAT_INTERVAL_MS: interval_reg       <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            first_reg      <= '0;
            last_reg       <= '0;
            repeating_reg  <= 1'b0;
            held_key_reg   <= '0;
            held_valid_reg <= 1'b0;
            stopped_reg    <= 1'b0;
        end else if (in_acc && !drop) begin
            first_reg      <= first_next;
            last_reg       <= last_next;
            repeating_reg  <= repeating_next;
            held_key_reg   <= held_key_next;
            held_valid_reg <= held_valid_next;
            stopped_reg    <= stopped_next;
        end else if (in_acc) begin
            // dropped report may still restart the repeat spacing
            last_reg <= last_next;
        end
    end

    // result buffer: slot 0 holds the first result of a transaction
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= 2'd0;
            head_reg <= 1'b0;
        end else if (in_acc) begin
            cnt_reg  <= n_res;
            head_reg <= 1'b0;
        end else if (out_acc) begin
            cnt_reg  <= cnt_reg - 2'd1;
            head_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_acc) begin
            res_reg[0] <= emit_rel ? rel_res : evt_res;
            res_reg[1] <= evt_res;
        end
    end

    a_stopped_sticks: assert property (@(posedge aclk) disable iff (!aresetn)
        stopped_reg |=> stopped_reg)
        else $error("stopped flag cleared without reset");

    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg != 2'd3)
        else $error("result buffer count out of range");

    a_stopped_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_acc && stopped_reg) |=> (cnt_reg == 2'd0))
        else $error("result produced while stopped");

    a_first_of_two: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg == 2'd2) |-> (!m_axis_tlast && m_axis_tdata[KEY_BITS+1]))
        else $error("first of two results must be a non-final release");

    a_held_cleared: assert property (@(posedge aclk) disable iff (!aresetn)
        !held_valid_reg |-> (held_key_reg == '0))
        else $error("held key not cleared while invalid");

endmodule
